/* hdl/tfpt_pkg.sv */
// ----------------------------------------------------------------------------
// tfpt_pkg
// Shared types and constants of the page translator with a FIFO-replaced TLB.
// ----------------------------------------------------------------------------
package tfpt_pkg;

	// Fixed field widths of an address, a frame id and a status.
	localparam int unsigned PAGE_W   = 5;
	localparam int unsigned OFFSET_W = 3;
	localparam int unsigned ADDR_W   = PAGE_W + OFFSET_W;
	localparam int unsigned FID_W    = 8;
	localparam int unsigned STATUS_W = 3;

	// Depth of the queue between front and back; must be a power of two.
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_HIT   = 3'd0,
		ST_FILL  = 3'd1,
		ST_RANGE = 3'd2,
		ST_FAULT = 3'd3,
		ST_INVAL = 3'd4
	} status_t;

	// Item class decided by the front part.
	typedef enum logic [1:0] {
		OP_XLATE,
		OP_RANGE,
		OP_INVAL
	} op_t;

	// Classified item as it travels through the queue.
	typedef struct packed {
		op_t                 op;
		logic [PAGE_W-1:0]   page;
		logic [OFFSET_W-1:0] offset;
		logic [FID_W-1:0]    frame_id;
	} cmd_t;

endpackage

/* hdl/tfpt_ifs.sv */
// ----------------------------------------------------------------------------
// tfpt_ifs
// Handshake channels of the translator: request items in, result items out.
// ----------------------------------------------------------------------------

// Request channel: one translate or invalidate item.
interface tfpt_req_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] virt_addr;
	logic [7:0] frame_id;

	modport source (output valid, output func, output virt_addr, output frame_id,
		input ready);
	modport sink (input valid, input func, input virt_addr, input frame_id,
		output ready);
endinterface

// Result channel: one physical address and status per item.
interface tfpt_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] phys_addr;
	logic [2:0] status;

	modport source (output valid, output phys_addr, output status, input ready);
	modport sink (input valid, input phys_addr, input status, output ready);
endinterface

/* hdl/tfpt_front.sv */
// ----------------------------------------------------------------------------
// tfpt_front
// Accepts request items, splits the address and classifies each item.
// ----------------------------------------------------------------------------
module tfpt_front #(
	parameter int unsigned PAGES = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	tfpt_req_if.sink       req,
	output logic           push_valid,
	input  logic           push_ready,
	output tfpt_pkg::cmd_t push_cmd
);
	import tfpt_pkg::*;

	logic              valid_s1;
	cmd_t              cmd_s1;
	cmd_t              cmd_d;
	logic [PAGE_W-1:0] page;

	// The stage takes a new item whenever it is empty or drains this cycle.
	assign req.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	// Split the address and decide the item class.
	assign page = req.virt_addr[ADDR_W-1:OFFSET_W];

	always_comb begin
		cmd_d.page     = page;
		cmd_d.offset   = req.virt_addr[OFFSET_W-1:0];
		cmd_d.frame_id = req.frame_id;
		if (req.func) begin
			cmd_d.op = OP_INVAL;
		end else if ({1'b0, page} >= (PAGE_W+1)'(PAGES)) begin
			cmd_d.op = OP_RANGE;
		end else begin
			cmd_d.op = OP_XLATE;
		end
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

/* hdl/tfpt_queue.sv */
// ----------------------------------------------------------------------------
// tfpt_queue
// Short FIFO of classified items between the front and the back part.
// ----------------------------------------------------------------------------
module tfpt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tfpt_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tfpt_pkg::cmd_t pop_cmd
);
	import tfpt_pkg::*;

	cmd_t            slots_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != (Q_AW+1)'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill level; pointers wrap naturally at a power-of-two depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// The fill level never exceeds the depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Q_AW+1)'(Q_DEPTH))
		else $error("queue fill level beyond depth");

	// Pointers stay apart by exactly the fill level.
	assert property (@(posedge clk) disable iff (!arst_n)
		(Q_AW)'(wr_ptr_q - rd_ptr_q) == count_q[Q_AW-1:0])
		else $error("queue pointers disagree with fill level");

endmodule

/* hdl/tfpt_back.sv */
// ----------------------------------------------------------------------------
// tfpt_back
// Carries out items: TLB lookup, page table check and fill, invalidation,
// and holds each result in an output register.
// ----------------------------------------------------------------------------
module tfpt_back #(
	parameter int unsigned PAGES       = 32,
	parameter int unsigned TLB_ENTRIES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  tfpt_pkg::cmd_t pop_cmd,
	tfpt_rsp_if.source     rsp
);
	import tfpt_pkg::*;

	localparam int unsigned VW  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam int unsigned PIW = (PAGES > 1) ? $clog2(PAGES) : 1;

	logic [PAGES-1:0]       page_valid_q;
	logic [PAGE_W-1:0]      tlb_page_q  [TLB_ENTRIES];
	logic [PAGE_W-1:0]      tlb_frame_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] tlb_valid_q;
	logic [VW-1:0]          victim_q;

	logic                   out_valid_q;
	logic [ADDR_W-1:0]      phys_q;
	status_t                status_q;

	logic                   work;
	logic [TLB_ENTRIES-1:0] match;
	logic                   hit;
	logic [PAGE_W-1:0]      hit_frame;
	logic                   pv;
	logic                   do_fill;
	logic [ADDR_W-1:0]      phys_d;
	status_t                status_d;

	// A new item is carried out when the output register is free or drains.
	assign pop_ready     = !out_valid_q || rsp.ready;
	assign work          = pop_valid && pop_ready;
	assign rsp.valid     = out_valid_q;
	assign rsp.phys_addr = phys_q;
	assign rsp.status    = status_q;

	// Associative match; a page is never held twice, so the matches OR together.
	always_comb begin
		hit_frame = '0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			match[i] = tlb_valid_q[i] && (tlb_page_q[i] == pop_cmd.page);
			if (match[i]) begin
				hit_frame = hit_frame | tlb_frame_q[i];
			end
		end
		hit = |match;
	end

	assign pv = page_valid_q[pop_cmd.page[PIW-1:0]];

	// Result and fill decision.
	always_comb begin
		phys_d   = '0;
		status_d = ST_INVAL;
		do_fill  = 1'b0;
		case (pop_cmd.op)
			OP_INVAL: begin
				status_d = ST_INVAL;
			end
			OP_RANGE: begin
				status_d = ST_RANGE;
			end
			OP_XLATE: begin
				if (hit) begin
					phys_d   = {hit_frame, pop_cmd.offset};
					status_d = ST_HIT;
				end else if (!pv) begin
					status_d = ST_FAULT;
				end else begin
					phys_d   = {pop_cmd.page, pop_cmd.offset};
					status_d = ST_FILL;
					do_fill  = 1'b1;
				end
			end
			default: begin
				status_d = ST_INVAL;
			end
		endcase
	end

	// Page table valid bits, TLB valid bits and the victim pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_valid_q <= '1;
			tlb_valid_q  <= '0;
			victim_q     <= '0;
		end else if (work) begin
			if (pop_cmd.op == OP_INVAL) begin
				for (int i = 0; i < PAGES; i++) begin
					if (pop_cmd.frame_id == FID_W'(i)) begin
						page_valid_q[i] <= 1'b0;
					end
				end
				for (int i = 0; i < TLB_ENTRIES; i++) begin
					if ({{(FID_W-PAGE_W){1'b0}}, tlb_frame_q[i]} == pop_cmd.frame_id) begin
						tlb_valid_q[i] <= 1'b0;
					end
				end
			end else if (do_fill) begin
				tlb_valid_q[victim_q] <= 1'b1;
				if (victim_q == VW'(TLB_ENTRIES - 1)) begin
					victim_q <= '0;
				end else begin
					victim_q <= victim_q + 1'b1;
				end
			end
		end
	end

	// TLB tags and frames; only read behind a valid bit.
	always_ff @(posedge clk) begin
		if (work && do_fill) begin
			tlb_page_q[victim_q]  <= pop_cmd.page;
			tlb_frame_q[victim_q] <= pop_cmd.page;
		end
	end

	// Output register flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (work) begin
			phys_q   <= phys_d;
			status_q <= status_d;
		end
	end

	// The victim pointer stays inside the TLB.
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(victim_q) < TLB_ENTRIES)
		else $error("victim pointer beyond TLB");

	// No page is held by two valid TLB entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("page held by more than one TLB entry");

	// Error and invalidate results carry a zero address.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_RANGE || status_q == ST_FAULT ||
		status_q == ST_INVAL)) |-> (phys_q == '0))
		else $error("non-zero address on error or invalidate result");

	// A filled entry is valid once the fill completes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(work && do_fill) |=> tlb_valid_q[$past(victim_q)])
		else $error("filled TLB entry not valid");

endmodule

/* hdl/tlb_fifo_page_translator_core.sv */
// ----------------------------------------------------------------------------
// tlb_fifo_page_translator_core
// Translates 8-bit virtual addresses through a FIFO-replaced TLB backed by an
// identity page table, and invalidates mappings by frame number.
// ----------------------------------------------------------------------------
//
//   Channel  Dir   Payload                          Handshake
//   req      in    func, virt_addr, frame_id        valid / ready
//   rsp      out   phys_addr, status                valid / ready
//
// One item is taken per cycle when nothing stalls. Each result passes through
// the front stage, the queue and the output register before it is presented
// on rsp. The back part carries out one item per cycle while rsp does not
// stall it, so its single lookup and update step sets the rate; the
// two-entry queue lets the front keep taking items while a result waits on
// rsp.
// Reset clears the TLB valid bits and the victim pointer and marks every page
// valid; no clearing pass is needed.
//
module tlb_fifo_page_translator_core #(
	parameter int unsigned PAGES       = 32,
	parameter int unsigned TLB_ENTRIES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	tfpt_req_if.sink   req,
	tfpt_rsp_if.source rsp
);
	import tfpt_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// Front: accept and classify.
	tfpt_front #(
		.PAGES (PAGES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Queue between front and back.
	tfpt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// Back: lookup, fill, invalidate and result register.
	tfpt_back #(
		.PAGES       (PAGES),
		.TLB_ENTRIES (TLB_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.rsp       (rsp)
	);

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page translator. A directed table walks
// through fills, hits, victim wrap-round, page faults and invalidation. A
// random phase then concentrates on a sliding window of pages so that TLB
// hits, evictions and faults all occur. Every result is checked against the
// directed table or a behavioural predictor. Both channels idle at random,
// and the receiver twice holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
	import tfpt_pkg::*;

	localparam int unsigned N_PAGES        = 32;
	localparam int unsigned N_TLB          = 8;
	localparam int unsigned RAND_ITEMS     = 450;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam int unsigned HOLD_CYCLES    = 60;

	// Request function codes.
	localparam bit FN_XLATE = 1'b0;
	localparam bit FN_INVAL = 1'b1;

	typedef struct packed {
		logic [7:0] phys;
		status_t    st;
	} xlat_res_t;

	typedef struct packed {
		bit         fn;
		logic [7:0] va;
		logic [7:0] fid;
		bit         typed;
		logic [7:0] phys;
		status_t    st;
	} dir_row_t;

	// Directed items; where typed is clear the predictor supplies the answer.
	localparam dir_row_t DIR_ROWS [24] = '{
		'{FN_XLATE, 8'hFF, 8'h00, 1'b1, 8'hFF, ST_FILL},
		'{FN_XLATE, 8'hF8, 8'hFF, 1'b1, 8'hF8, ST_HIT},
		'{FN_XLATE, 8'h00, 8'hFF, 1'b1, 8'h00, ST_FILL},
		'{FN_XLATE, 8'h07, 8'h00, 1'b1, 8'h07, ST_HIT},
		'{FN_INVAL, 8'hFF, 8'd31, 1'b1, 8'h00, ST_INVAL},
		'{FN_XLATE, 8'hFB, 8'h00, 1'b1, 8'h00, ST_FAULT},
		'{FN_INVAL, 8'h00, 8'hFF, 1'b1, 8'h00, ST_INVAL},
		'{FN_INVAL, 8'hAA, 8'd32, 1'b1, 8'h00, ST_INVAL},
		'{FN_INVAL, 8'h00, 8'd31, 1'b1, 8'h00, ST_INVAL},
		'{FN_XLATE, 8'h09, 8'h80, 1'b0, 8'h00, ST_HIT},
		'{FN_XLATE, 8'h12, 8'h01, 1'b0, 8'h00, ST_HIT},
		'{FN_XLATE, 8'h1B, 8'h02, 1'b0, 8'h00, ST_HIT},
		'{FN_XLATE, 8'h24, 8'h04, 1'b0, 8'h00, ST_HIT},
		'{FN_XLATE, 8'h2D, 8'h08, 1'b0, 8'h00, ST_HIT},
		'{FN_XLATE, 8'h36, 8'h10, 1'b0, 8'h00, ST_HIT},
		'{FN_XLATE, 8'h3F, 8'h20, 1'b0, 8'h00, ST_HIT},
		'{FN_XLATE, 8'h40, 8'h40, 1'b0, 8'h00, ST_HIT},
		'{FN_XLATE, 8'h03, 8'h00, 1'b0, 8'h00, ST_HIT},
		'{FN_XLATE, 8'h41, 8'h00, 1'b0, 8'h00, ST_HIT},
		'{FN_INVAL, 8'h41, 8'd8,  1'b1, 8'h00, ST_INVAL},
		'{FN_XLATE, 8'h47, 8'h00, 1'b1, 8'h00, ST_FAULT},
		'{FN_XLATE, 8'h55, 8'hAA, 1'b0, 8'h00, ST_HIT},
		'{FN_INVAL, 8'h00, 8'd0,  1'b1, 8'h00, ST_INVAL},
		'{FN_XLATE, 8'hAA, 8'h55, 1'b0, 8'h00, ST_HIT}
	};

	logic clk;
	logic arst_n;

	tfpt_req_if req_ch ();
	tfpt_rsp_if rsp_ch ();

	tlb_fifo_page_translator_core #(
		.PAGES       (N_PAGES),
		.TLB_ENTRIES (N_TLB)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Predicted state of the page table and the TLB.
	bit         page_live [N_PAGES];
	logic [4:0] tlb_pg    [N_TLB];
	logic [4:0] tlb_fr    [N_TLB];
	bit         tlb_live  [N_TLB];
	int         victim;

	xlat_res_t  expected_res [$];
	int         fail_count;
	int         quiet_cycles;
	bit         calm;
	bit         squeeze;

	// Clock generation.
	initial begin
		clk = 1'b0;
	end
	always #4 clk = ~clk;

	// Gap length: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Works out the answer to one item and updates the predicted state.
	function automatic xlat_res_t predict_xlate(bit fn, logic [7:0] va, logic [7:0] fid);
		xlat_res_t  res;
		logic [4:0] pg;
		logic [2:0] off;
		int         hit;
		if (fn == FN_INVAL) begin
			if (fid < N_PAGES)
				page_live[fid] = 1'b0;
			for (int i = 0; i < N_TLB; i++)
				if (tlb_live[i] && {3'b000, tlb_fr[i]} == fid)
					tlb_live[i] = 1'b0;
			res = '{8'h00, ST_INVAL};
			return res;
		end
		pg  = va[7:3];
		off = va[2:0];
		// Cannot occur while every 5-bit page number is mapped.
		if (pg >= N_PAGES) begin
			res = '{8'h00, ST_RANGE};
			return res;
		end
		// Lowest matching entry wins.
		hit = -1;
		for (int i = N_TLB - 1; i >= 0; i--)
			if (tlb_live[i] && tlb_pg[i] == pg)
				hit = i;
		if (hit >= 0) begin
			res = '{{tlb_fr[hit], off}, ST_HIT};
			return res;
		end
		if (!page_live[pg]) begin
			res = '{8'h00, ST_FAULT};
			return res;
		end
		// Miss on a valid page: fill the FIFO victim with the identity mapping.
		tlb_pg[victim]   = pg;
		tlb_fr[victim]   = pg;
		tlb_live[victim] = 1'b1;
		victim           = (victim + 1) % N_TLB;
		res = '{{pg, off}, ST_FILL};
		return res;
	endfunction

	// Offers one item and returns at the edge where it is taken.
	task automatic offer(bit fn, logic [7:0] va, logic [7:0] fid);
		req_ch.valid     <= 1'b1;
		req_ch.func      <= fn;
		req_ch.virt_addr <= va;
		req_ch.frame_id  <= fid;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
	endtask

	// Idles the request side for a random gap, unless running flat out.
	task automatic pause();
		int n;
		n = (calm || squeeze) ? 0 : idle_len();
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Compares one accepted result with the oldest expectation.
	task automatic check_result();
		xlat_res_t want;
		if (expected_res.size() == 0) begin
			$error("unexpected result: phys_addr %02h status %0d",
				rsp_ch.phys_addr, rsp_ch.status);
			fail_count++;
			return;
		end
		want = expected_res.pop_front();
		if (rsp_ch.phys_addr !== want.phys) begin
			$error("phys_addr: expected %02h, actual %02h", want.phys, rsp_ch.phys_addr);
			fail_count++;
		end
		if (rsp_ch.status !== want.st) begin
			$error("status: expected %0d, actual %0d", want.st, rsp_ch.status);
			fail_count++;
		end
	endtask

	// Result side: random back-pressure, with two long hold-offs.
	initial begin
		int stall;
		int n_seen;
		int hold;
		stall        = 0;
		n_seen       = 0;
		hold         = 0;
		squeeze      = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				check_result();
				n_seen++;
				if (n_seen == 120 || n_seen == 330)
					hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				squeeze = 1'b1;
				hold--;
				rsp_ch.ready <= 1'b0;
			end else begin
				squeeze = 1'b0;
				if (stall > 0) begin
					stall--;
					rsp_ch.ready <= 1'b0;
				end else begin
					stall = calm ? 0 : idle_len();
					rsp_ch.ready <= (stall == 0);
				end
			end
		end
	end

	// Watchdog: ends the run if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tlb_fifo_page_translator_core: mismatch");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		xlat_res_t  res;
		bit         fn;
		logic [7:0] va;
		logic [7:0] fid;
		logic [4:0] pg;
		logic [2:0] off;
		int         win_base;
		int         r;

		fail_count   = 0;
		quiet_cycles = 0;
		calm         = 1'b0;
		win_base     = 0;
		victim       = 0;
		for (int i = 0; i < N_PAGES; i++)
			page_live[i] = 1'b1;
		for (int i = 0; i < N_TLB; i++) begin
			tlb_pg[i]   = '0;
			tlb_fr[i]   = '0;
			tlb_live[i] = 1'b0;
		end

		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.func      = FN_XLATE;
		req_ch.virt_addr = '0;
		req_ch.frame_id  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (int k = 0; k < $size(DIR_ROWS); k++) begin
			offer(DIR_ROWS[k].fn, DIR_ROWS[k].va, DIR_ROWS[k].fid);
			res = predict_xlate(DIR_ROWS[k].fn, DIR_ROWS[k].va, DIR_ROWS[k].fid);
			if (DIR_ROWS[k].typed)
				res = '{DIR_ROWS[k].phys, DIR_ROWS[k].st};
			expected_res.push_back(res);
			pause();
		end

		// Random items, mostly within a sliding window of twelve pages so
		// that the TLB both hits and evicts; invalidates are rarer and
		// often name frames that do not exist.
		for (int k = 0; k < RAND_ITEMS; k++) begin
			calm = (k % 70) >= 55;
			if (k % 80 == 0 && k != 0)
				win_base = (win_base + 5) % N_PAGES;
			if ($urandom_range(0, 9) == 0) begin
				fn = FN_INVAL;
				va = 8'($urandom);
				r  = $urandom_range(0, 9);
				if (r < 6)
					fid = 8'($urandom_range(32, 255));
				else if (r < 9)
					fid = 8'((win_base + $urandom_range(0, 11)) % N_PAGES);
				else
					fid = 8'($urandom_range(0, 31));
			end else begin
				fn  = FN_XLATE;
				fid = 8'($urandom);
				off = 3'($urandom);
				if ($urandom_range(0, 9) < 7)
					pg = 5'((win_base + $urandom_range(0, 11)) % N_PAGES);
				else
					pg = 5'($urandom_range(0, 31));
				va = {pg, off};
			end
			offer(fn, va, fid);
			expected_res.push_back(predict_xlate(fn, va, fid));
			pause();
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		// Drain and settle.
		while (expected_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tlb_fifo_page_translator_core: match");
		else
			$display("tlb_fifo_page_translator_core: mismatch");
		$finish;
	end

endmodule
